// File: src/smc_pkg.sv
`default_nettype none
package smc_pkg;

  localparam int FFT_BINS   = 1024;
  localparam int LO_STEPS   = 16;
  localparam int TOTAL_BINS = FFT_BINS * LO_STEPS;
  localparam int ADDR_W     = $clog2(TOTAL_BINS);

  localparam int OP_W    = 3;
  localparam int LO_W    = 4;
  localparam int BIN_W   = 10;
  localparam int MAG_W   = 24;
  localparam int PEAK_W  = 23;
  localparam int ACC_W   = 32;
  localparam int MASK_W  = 17;
  localparam int FRAME_W = 16;
  localparam int QUO_W   = 16;

  localparam logic [MASK_W-1:0]  Q_ONE     = MASK_W'(65536);
  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;
  localparam logic [ACC_W-1:0]   ACC_MAX   = '1;

  typedef enum logic [OP_W-1:0] {
    OP_START = 3'd0,
    OP_ACCUM = 3'd1,
    OP_END   = 3'd2,
    OP_FIN   = 3'd3,
    OP_CLEAR = 3'd4,
    OP_READ  = 3'd5
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic addr_load;
    logic addr_clear;
    logic addr_inc;
    logic acc_rd;
    logic acc_wr;
    logic mask_rd;
    logic mask_wr;
    logic zero_wr;
    logic div_start;
    logic div_fin;
    logic frame_clear;
    logic frame_inc;
    logic active_set;
    logic active_clear;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic acc_ok;
    logic in_range;
    logic frame_nz;
    logic norm_direct;
    logic fin_direct;
    logic addr_last;
    logic div_done;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// File: src/smc_in_if.sv
`default_nettype none
interface smc_in_if;
  import smc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [LO_W-1:0]          lo_index;
  logic [BIN_W-1:0]         bin_index;
  logic signed [MAG_W-1:0]  sample_magnitude;
  logic [PEAK_W-1:0]        frame_peak;

  modport source (output valid, opcode, lo_index, bin_index, sample_magnitude, frame_peak,
                  input ready);
  modport sink (input valid, opcode, lo_index, bin_index, sample_magnitude, frame_peak,
                output ready);
endinterface
`default_nettype wire

// File: src/smc_out_if.sv
`default_nettype none
interface smc_out_if;
  import smc_pkg::*;
  logic               valid;
  logic               ready;
  logic [MASK_W-1:0]  mask_value;
  logic               active;
  logic [FRAME_W-1:0] frames_counted;
  logic               applied;

  modport source (output valid, mask_value, active, frames_counted, applied, input ready);
  modport sink (input valid, mask_value, active, frames_counted, applied, output ready);
endinterface
`default_nettype wire

// File: src/smc_div.sv
`default_nettype none
module smc_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [smc_pkg::PEAK_W-1:0] dividend_hi,
  input  wire logic [smc_pkg::QUO_W-1:0]  dividend_lo,
  input  wire logic [smc_pkg::PEAK_W-1:0] divisor,
  output logic                            busy,
  output logic                            done,
  output logic [smc_pkg::QUO_W-1:0]       quotient
);
  import smc_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [PEAK_W-1:0] rem;
  logic [PEAK_W-1:0] dvs;
  logic [QUO_W-1:0]  lo_sh;
  logic [CNT_W-1:0]  cnt;
  logic [PEAK_W:0]   trial;
  logic              fits;

  // one restoring step: shift in the next dividend bit and try a subtract
  assign trial = {rem, lo_sh[QUO_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend_hi;
      lo_sh    <= dividend_lo;
      dvs      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? PEAK_W'(trial - {1'b0, dvs}) : trial[PEAK_W-1:0];
      lo_sh    <= {lo_sh[QUO_W-2:0], 1'b0};
      quotient <= {quotient[QUO_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// File: src/smc_dp.sv
`default_nettype none
module smc_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire smc_pkg::cmd_t               cmd,
  output smc_pkg::status_t                 st,
  input  wire logic [smc_pkg::OP_W-1:0]    opcode,
  input  wire logic [smc_pkg::LO_W-1:0]    lo_index,
  input  wire logic [smc_pkg::BIN_W-1:0]   bin_index,
  input  wire logic [smc_pkg::MAG_W-1:0]   sample_magnitude,
  input  wire logic [smc_pkg::PEAK_W-1:0]  frame_peak,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [smc_pkg::MASK_W-1:0]       mask_value,
  output logic                             active,
  output logic [smc_pkg::FRAME_W-1:0]      frames_counted,
  output logic                             applied
);
  import smc_pkg::*;

  logic [OP_W-1:0]   op_q;
  logic [LO_W-1:0]   lo_q;
  logic [BIN_W-1:0]  bin_q;
  logic [MAG_W-1:0]  mag_q;
  logic [PEAK_W-1:0] peak_q;

  logic [ADDR_W-1:0]  addr;
  logic [FRAME_W-1:0] frame_count;
  logic               active_flag;

  logic [ACC_W-1:0]  accum_mem [TOTAL_BINS];
  logic [MASK_W-1:0] mask_mem  [TOTAL_BINS];
  logic [ACC_W-1:0]  acc_rdata;
  logic [MASK_W-1:0] mask_rdata;

  logic              in_range;
  logic [ADDR_W-1:0] item_addr;
  logic              mag_zero_out;
  logic [MASK_W-1:0] norm_val;
  logic [ACC_W:0]    acc_sum;
  logic [ACC_W-1:0]  acc_wdata;
  logic [MASK_W-1:0] mask_wdata;
  logic              applied_next;

  logic [PEAK_W-1:0] div_hi;
  logic [QUO_W-1:0]  div_lo;
  logic [PEAK_W-1:0] div_d;
  logic              div_busy;
  logic              div_done;
  logic [QUO_W-1:0]  quo;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= opcode;
      lo_q   <= lo_index;
      bin_q  <= bin_index;
      mag_q  <= sample_magnitude;
      peak_q <= frame_peak;
    end
  end

  assign in_range  = (int'(lo_q) < LO_STEPS) && (int'(bin_q) < FFT_BINS);
  assign item_addr = ADDR_W'(int'(lo_q) * FFT_BINS + int'(bin_q));

  // bin address / sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else if (cmd.addr_clear) begin
      addr <= '0;
    end else if (cmd.addr_load) begin
      addr <= item_addr;
    end else if (cmd.addr_inc) begin
      addr <= addr + 1'b1;
    end
  end

  // frame count and active flag
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      active_flag <= 1'b0;
    end else begin
      if (cmd.frame_clear) begin
        frame_count <= '0;
      end else if (cmd.frame_inc && frame_count != FRAME_MAX) begin
        frame_count <= frame_count + 1'b1;
      end
      if (cmd.active_clear) begin
        active_flag <= 1'b0;
      end else if (cmd.active_set) begin
        active_flag <= 1'b1;
      end
    end
  end

  // normalized value: negative or zero magnitude gives 0, at or above peak gives one
  assign mag_zero_out = mag_q[MAG_W-1] || (mag_q == '0);
  always_comb begin
    if (mag_zero_out) begin
      norm_val = '0;
    end else if (mag_q[PEAK_W-1:0] >= peak_q) begin
      norm_val = Q_ONE;
    end else begin
      norm_val = {1'b0, quo};
    end
  end

  // saturating accumulate
  assign acc_sum   = {1'b0, acc_rdata} + (ACC_W + 1)'(norm_val);
  assign acc_wdata = cmd.zero_wr ? '0 : (acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0]);

  // mask entry saturates at one when acc / count reaches 65536
  assign mask_wdata = cmd.zero_wr ? '0 :
                      (st.fin_direct ? Q_ONE : {1'b0, quo});

  // shared divider operands
  assign div_hi = cmd.div_fin ? PEAK_W'(acc_rdata[ACC_W-1:QUO_W]) : mag_q[PEAK_W-1:0];
  assign div_lo = cmd.div_fin ? acc_rdata[QUO_W-1:0] : '0;
  assign div_d  = cmd.div_fin ? PEAK_W'(frame_count) : peak_q;

  smc_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (cmd.div_start),
    .dividend_hi (div_hi),
    .dividend_lo (div_lo),
    .divisor     (div_d),
    .busy        (div_busy),
    .done        (div_done),
    .quotient    (quo)
  );

  // accumulator memory
  always_ff @(posedge clk) begin
    if (cmd.acc_wr) begin
      accum_mem[addr] <= acc_wdata;
    end
    if (cmd.acc_rd) begin
      acc_rdata <= accum_mem[addr];
    end
  end

  // mask memory
  always_ff @(posedge clk) begin
    if (cmd.mask_wr) begin
      mask_mem[addr] <= mask_wdata;
    end
    if (cmd.mask_rd) begin
      mask_rdata <= mask_mem[addr];
    end
  end

  // status
  always_comb begin
    st.op          = op_t'(op_q);
    st.acc_ok      = (peak_q != '0) && in_range;
    st.in_range    = in_range;
    st.frame_nz    = frame_count != '0;
    st.norm_direct = mag_zero_out || (mag_q[PEAK_W-1:0] >= peak_q);
    st.fin_direct  = acc_rdata[ACC_W-1:QUO_W] >= frame_count;
    st.addr_last   = addr == ADDR_W'(TOTAL_BINS - 1);
    st.div_done    = div_done;
    st.div_busy    = div_busy;
    st.out_free    = !out_valid || out_ready;
  end

  always_comb begin
    case (op_t'(op_q))
      OP_START, OP_END, OP_CLEAR: applied_next = 1'b1;
      OP_ACCUM:                   applied_next = st.acc_ok;
      OP_FIN:                     applied_next = st.frame_nz;
      OP_READ:                    applied_next = in_range;
      default:                    applied_next = 1'b0;
    endcase
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mask_value     <= (op_t'(op_q) == OP_READ && in_range) ? mask_rdata : '0;
      active         <= active_flag;
      frames_counted <= frame_count;
      applied        <= applied_next;
    end
  end

endmodule
`default_nettype wire

// File: src/smc_ctrl.sv
`default_nettype none
module smc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire smc_pkg::status_t    st,
  output smc_pkg::cmd_t            cmd
);
  import smc_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DISPATCH = 12'b0000_0000_0010,
    S_SWEEP    = 12'b0000_0000_0100,
    S_ACC_RD   = 12'b0000_0000_1000,
    S_ACC_CHK  = 12'b0000_0001_0000,
    S_ACC_DIV  = 12'b0000_0010_0000,
    S_ACC_WR   = 12'b0000_0100_0000,
    S_FIN_RD   = 12'b0000_1000_0000,
    S_FIN_CHK  = 12'b0001_0000_0000,
    S_FIN_DIV  = 12'b0010_0000_0000,
    S_RD_MASK  = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;
  logic   sweep_mask, sweep_mask_next;
  logic   sweep_reply, sweep_reply_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_mask  <= 1'b1;
      sweep_reply <= 1'b0;
    end else begin
      state       <= state_next;
      sweep_mask  <= sweep_mask_next;
      sweep_reply <= sweep_reply_next;
    end
  end

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next       = state;
    sweep_mask_next  = sweep_mask;
    sweep_reply_next = sweep_reply;
    cmd              = '0;
    cmd.latch        = in_valid && in_ready;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.op)
          OP_START: begin
            cmd.addr_clear   = 1'b1;
            cmd.frame_clear  = 1'b1;
            sweep_mask_next  = 1'b0;
            sweep_reply_next = 1'b1;
            state_next       = S_SWEEP;
          end
          OP_ACCUM: begin
            cmd.addr_load = st.acc_ok;
            state_next    = st.acc_ok ? S_ACC_RD : S_DONE;
          end
          OP_END: begin
            cmd.frame_inc = 1'b1;
            state_next    = S_DONE;
          end
          OP_FIN: begin
            cmd.addr_clear = st.frame_nz;
            state_next     = st.frame_nz ? S_FIN_RD : S_DONE;
          end
          OP_CLEAR: begin
            cmd.addr_clear   = 1'b1;
            cmd.frame_clear  = 1'b1;
            cmd.active_clear = 1'b1;
            sweep_mask_next  = 1'b1;
            sweep_reply_next = 1'b1;
            state_next       = S_SWEEP;
          end
          OP_READ: begin
            cmd.addr_load = st.in_range;
            state_next    = st.in_range ? S_RD_MASK : S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      // zero one entry per cycle
      S_SWEEP: begin
        cmd.acc_wr   = 1'b1;
        cmd.mask_wr  = sweep_mask;
        cmd.zero_wr  = 1'b1;
        cmd.addr_inc = 1'b1;
        if (st.addr_last) begin
          state_next = sweep_reply ? S_DONE : S_IDLE;
        end
      end
      S_ACC_RD: begin
        cmd.acc_rd = 1'b1;
        state_next = S_ACC_CHK;
      end
      S_ACC_CHK: begin
        if (st.norm_direct) begin
          state_next = S_ACC_WR;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_ACC_DIV;
        end
      end
      S_ACC_DIV: begin
        if (st.div_done) begin
          state_next = S_ACC_WR;
        end
      end
      S_ACC_WR: begin
        cmd.acc_wr = 1'b1;
        state_next = S_DONE;
      end
      S_FIN_RD: begin
        cmd.acc_rd = 1'b1;
        state_next = S_FIN_CHK;
      end
      S_FIN_CHK, S_FIN_DIV: begin
        if ((state == S_FIN_CHK && st.fin_direct) || (state == S_FIN_DIV && st.div_done)) begin
          cmd.mask_wr = 1'b1;
          if (st.addr_last) begin
            cmd.active_set = 1'b1;
            state_next     = S_DONE;
          end else begin
            cmd.addr_inc = 1'b1;
            state_next   = S_FIN_RD;
          end
        end else if (state == S_FIN_CHK) begin
          cmd.div_start = 1'b1;
          cmd.div_fin   = 1'b1;
          state_next    = S_FIN_DIV;
        end
      end
      S_RD_MASK: begin
        cmd.mask_rd = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: src/spur_mask_calibrator.sv
// accumulate: read, check, then the 16-step shared divider when it runs or a bypass, then write
// read: dispatch, mask read, output; end frame, unknown opcodes and ignored beats: dispatch, output
// start and clear: one entry zeroed per cycle over all 16384, accumulator only for start, both stores for clear
// finalize: per bin read, check and divide when needed, over 16384 bins, one read port and the divider
// reset: synchronous; clears control state and then sweeps all 16384 entries of
// both stores before the first input beat is taken; a held output beat stalls each reply
`default_nettype none
module spur_mask_calibrator (
  input  wire logic clk,
  input  wire logic rst,
  smc_in_if.sink    in_ch,
  smc_out_if.source out_ch
);
  import smc_pkg::*;

  cmd_t    cmd;
  status_t st;

  smc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  smc_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .opcode           (in_ch.opcode),
    .lo_index         (in_ch.lo_index),
    .bin_index        (in_ch.bin_index),
    .sample_magnitude (in_ch.sample_magnitude),
    .frame_peak       (in_ch.frame_peak),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .mask_value       (out_ch.mask_value),
    .active           (out_ch.active),
    .frames_counted   (out_ch.frames_counted),
    .applied          (out_ch.applied)
  );

`ifndef SYNTHESIS
  // divider is never restarted mid-operation
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |-> !st.div_busy)
    else $error("divider started while busy");

  // no new beat is taken while the divider runs
  assert property (@(posedge clk) disable iff (rst) st.div_busy |-> !in_ch.ready)
    else $error("input ready during division");

  // mask writes only happen while no beat is being taken
  assert property (@(posedge clk) disable iff (rst) cmd.mask_wr |-> !in_ch.ready)
    else $error("mask write while idle");

  // a result is only loaded into a free output register
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("output overwritten");
`endif

endmodule
`default_nettype wire
